/* hdl/rsld_pkg.sv */
// Shared types, constants and helper functions of the rotating sector light driver.
package rsld_pkg;

   localparam int KNOB_W  = 11;
   localparam int LEVEL_W = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Rotation time scaled by 1024 never exceeds 65535 * 1024, so 26 bits hold it.
   localparam int TIME_W = 26;
   localparam int STEP_W = 10;
   localparam int MUL_B_W = 15;

   localparam logic [KNOB_W-1:0] KNOB_FULL  = 11'd1024;
   localparam logic [KNOB_W-1:0] SPEED_DEAD = 11'd51;

   localparam logic [CSR_IDX_W-1:0] REG_STEP_PERIOD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_TIME_MIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROT_TIME_MAX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_PHASE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_MIN    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_MAX    = 3'd5;

   typedef struct packed {
      logic [KNOB_W-1:0] light_level;
      logic [KNOB_W-1:0] pan_offset;
      logic [KNOB_W-1:0] sector_width_knob;
      logic [KNOB_W-1:0] speed_knob;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] dimmer_level;
      logic [LEVEL_W-1:0] red_level;
      logic [LEVEL_W-1:0] green_level;
      logic [LEVEL_W-1:0] blue_level;
      logic [LEVEL_W-1:0] white_level;
      logic [LEVEL_W-1:0] pan_level;
      logic [LEVEL_W-1:0] slow_speed_out;
      logic [LEVEL_W-1:0] fast_speed_out;
   } rsp_type;

   // Knob values above full scale are treated as full scale.
   function automatic logic [KNOB_W-1:0] sat_knob(input logic [KNOB_W-1:0] value);
      sat_knob = (value > KNOB_FULL) ? KNOB_FULL : value;
   endfunction

endpackage

/* hdl/rsld_req_if.sv */
// Request channel interface of the rotating sector light driver.
interface rsld_req_if;
   logic              valid;
   logic              ready;
   rsld_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* hdl/rsld_rsp_if.sv */
// Result channel interface of the rotating sector light driver.
interface rsld_rsp_if;
   logic              valid;
   logic              ready;
   rsld_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* hdl/rotating_sector_light_driver.sv */
// Top level of the rotating sector light driver: sequencer, shared multiplier and serial divider.
//
// Each request is one tick of the step period. The block advances the beam phase by an
// increment derived from the speed knob and the rotation-time registers, picks the color
// from where the phase sits against a sector centered on half a turn, and returns one
// response with dimmer, color, pan and the two fixed speed levels. After acceptance the
// block runs two multiply steps, then the restoring divider, which produces one quotient
// bit per cycle over the PHASE_BITS + 20 bit dividend, then the phase update, the sector
// product and the response load, which waits until the output register is free. The block
// is not ready while a request is being worked on, but it takes a new request while a
// finished response still waits in the output register. Configuration registers are
// written through the csr port and are expected to change only while the block is idle.
module rotating_sector_light_driver #(
   parameter int PHASE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   rsld_req_if.sink                           req_chan,
   rsld_rsp_if.source                         rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [rsld_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rsld_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rsld_pkg::*;

   // The dividend is step << (PHASE_BITS + 10), so the divider walks over this many bits.
   localparam int DIV_N   = PHASE_BITS + 20;
   localparam int CNT_W   = $clog2(DIV_N);
   localparam int MUL_A_W = (PHASE_BITS > 16) ? PHASE_BITS : 16;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int PAN_W   = PHASE_BITS + 16;
   localparam int SCL_W   = PHASE_BITS + MUL_B_W;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_MUL_MIN = 3'd1;
   localparam logic [2:0] ST_MUL_MAX = 3'd2;
   localparam logic [2:0] ST_DIV     = 3'd3;
   localparam logic [2:0] ST_PHASE   = 3'd4;
   localparam logic [2:0] ST_SECTOR  = 3'd5;
   localparam logic [2:0] ST_DONE    = 3'd6;

   // Configuration registers.
   logic [STEP_W-1:0]     step_period_ff;
   logic [15:0]           rot_min_ff;
   logic [15:0]           rot_max_ff;
   logic [15:0]           center_phase_ff;
   logic [LEVEL_W-1:0]    speed_min_ff;
   logic [LEVEL_W-1:0]    speed_max_ff;

   // Sequencer and datapath registers.
   logic [2:0]            state_ff, state_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [KNOB_W-1:0]     light_ff, light_in;
   logic [KNOB_W-1:0]     offset_ff, offset_in;
   logic [KNOB_W-1:0]     width_ff, width_in;
   logic [KNOB_W-1:0]     sabs_ff, sabs_in;
   logic                  reverse_ff, reverse_in;
   logic [MUL_P_W-1:0]    prod_ff, prod_in;
   logic [TIME_W-1:0]     time_ff, time_in;
   logic [TIME_W-1:0]     rem_ff, rem_in;
   logic [STEP_W-1:0]     step_sr_ff, step_sr_in;
   logic [PHASE_BITS-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic [KNOB_W-1:0]     speed_sat;
   logic [KNOB_W:0]       speed_x2;
   logic [KNOB_W:0]       sabs_wide;
   logic [MUL_A_W-1:0]    mul_a;
   logic [MUL_B_W-1:0]    mul_b;
   logic [MUL_P_W-1:0]    mul_p;
   logic [TIME_W:0]       rem_trial;
   logic [TIME_W+1:0]     rem_diff;
   logic [PHASE_BITS-1:0] phase_inc;
   logic [KNOB_W+6:0]     light_x255;
   logic [LEVEL_W-1:0]    full_lvl;
   logic [LEVEL_W-1:0]    half_lvl;
   logic [LEVEL_W+7:0]    fifth_prod;
   logic [LEVEL_W-1:0]    fifth_lvl;
   logic [MUL_B_W-1:0]    width_x7;
   logic [MUL_B_W-1:0]    lo_bound;
   logic [MUL_B_W-1:0]    hi_bound;
   logic [SCL_W-1:0]      scaled;
   logic [PAN_W-1:0]      pan_sum;
   logic                  req_fire;
   logic                  rsp_free;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   // Signed speed s = 2K - 1024 is kept as a magnitude and a direction flag.
   assign speed_sat = sat_knob(req_chan.data.speed_knob);
   assign speed_x2  = {speed_sat, 1'b0};
   assign sabs_wide = (speed_x2 < {1'b0, KNOB_FULL}) ? ({1'b0, KNOB_FULL} - speed_x2)
                                                    : (speed_x2 - {1'b0, KNOB_FULL});

   // The one multiplier is shared by both rotation-time terms and the sector product.
   always_comb begin
      unique case (state_ff)
         ST_MUL_MIN: begin
            mul_a = MUL_A_W'(rot_min_ff);
            mul_b = MUL_B_W'(sabs_ff);
         end
         ST_MUL_MAX: begin
            mul_a = MUL_A_W'(rot_max_ff);
            mul_b = MUL_B_W'(KNOB_FULL - sabs_ff);
         end
         default: begin
            mul_a = MUL_A_W'(phase_ff);
            mul_b = 15'd20480;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // One restoring division step per cycle; the remainder stays below a nonzero divisor.
   assign rem_trial = {rem_ff, step_sr_ff[STEP_W-1]};
   assign rem_diff  = {1'b0, rem_trial} - {2'b00, time_ff};

   // A dead band around still, or a zero rotation time, freezes the beam.
   assign phase_inc = ((sabs_ff < SPEED_DEAD) || (time_ff == '0)) ? '0 : quot_ff;

   // Levels scaled by the light knob; a fifth comes from 205/1024, exact for 0..255.
   assign light_x255 = light_ff * 8'd255;
   assign full_lvl   = light_x255[KNOB_W+6:10];
   assign half_lvl   = {1'b0, light_x255[KNOB_W+6:11]};
   assign fifth_prod = full_lvl * 8'd205;
   assign fifth_lvl  = {2'b00, fifth_prod[LEVEL_W+7:10]};

   // Sector bounds, in units of 1/20480 turn, compared against phase * 20480.
   assign width_x7 = MUL_B_W'(width_ff) * 15'd7;
   assign lo_bound = 15'd9728 - width_x7;
   assign hi_bound = 15'd10752 + width_x7;
   assign scaled   = prod_ff[SCL_W-1:0];

   // Pan is the sum of phase, center and offset in Q0.(PHASE_BITS+16), wrapped to a turn.
   assign pan_sum = {phase_ff, 16'd0}
                  + {center_phase_ff, {PHASE_BITS{1'b0}}}
                  + {offset_ff[KNOB_W-2:0], {(PHASE_BITS + 6){1'b0}}};

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      light_in     = light_ff;
      offset_in    = offset_ff;
      width_in     = width_ff;
      sabs_in      = sabs_ff;
      reverse_in   = reverse_ff;
      prod_in      = prod_ff;
      time_in      = time_ff;
      rem_in       = rem_ff;
      step_sr_in   = step_sr_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               light_in   = sat_knob(req_chan.data.light_level);
               offset_in  = sat_knob(req_chan.data.pan_offset);
               width_in   = sat_knob(req_chan.data.sector_width_knob);
               sabs_in    = sabs_wide[KNOB_W-1:0];
               reverse_in = (speed_x2 < {1'b0, KNOB_FULL});
               state_in   = ST_MUL_MIN;
            end
         end
         ST_MUL_MIN: begin
            prod_in  = mul_p;
            state_in = ST_MUL_MAX;
         end
         ST_MUL_MAX: begin
            time_in    = prod_ff[TIME_W-1:0] + mul_p[TIME_W-1:0];
            rem_in     = '0;
            step_sr_in = step_period_ff;
            quot_in    = '0;
            cnt_in     = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            step_sr_in = {step_sr_ff[STEP_W-2:0], 1'b0};
            if (!rem_diff[TIME_W+1]) begin
               rem_in  = rem_diff[TIME_W-1:0];
               quot_in = {quot_ff[PHASE_BITS-2:0], 1'b1};
            end else begin
               rem_in  = rem_trial[TIME_W-1:0];
               quot_in = {quot_ff[PHASE_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_N - 1)) begin
               state_in = ST_PHASE;
            end
         end
         ST_PHASE: begin
            phase_in = reverse_ff ? (phase_ff - phase_inc) : (phase_ff + phase_inc);
            state_in = ST_SECTOR;
         end
         ST_SECTOR: begin
            prod_in  = mul_p;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_data_in.dimmer_level   = full_lvl;
               rsp_data_in.pan_level      = pan_sum[PAN_W-1 -: LEVEL_W];
               rsp_data_in.slow_speed_out = speed_min_ff;
               rsp_data_in.fast_speed_out = speed_max_ff;
               if (scaled < {lo_bound, {PHASE_BITS{1'b0}}}) begin
                  rsp_data_in.red_level   = '0;
                  rsp_data_in.green_level = full_lvl;
                  rsp_data_in.blue_level  = '0;
                  rsp_data_in.white_level = '0;
               end else if (scaled < {hi_bound, {PHASE_BITS{1'b0}}}) begin
                  rsp_data_in.red_level   = half_lvl;
                  rsp_data_in.green_level = half_lvl;
                  rsp_data_in.blue_level  = fifth_lvl;
                  rsp_data_in.white_level = full_lvl;
               end else begin
                  rsp_data_in.red_level   = full_lvl;
                  rsp_data_in.green_level = '0;
                  rsp_data_in.blue_level  = '0;
                  rsp_data_in.white_level = '0;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      light_ff    <= light_in;
      offset_ff   <= offset_in;
      width_ff    <= width_in;
      sabs_ff     <= sabs_in;
      reverse_ff  <= reverse_in;
      prod_ff     <= prod_in;
      time_ff     <= time_in;
      rem_ff      <= rem_in;
      step_sr_ff  <= step_sr_in;
      quot_ff     <= quot_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Register file; a write to an index beyond the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_period_ff  <= 10'd20;
         rot_min_ff      <= 16'd1000;
         rot_max_ff      <= 16'd20000;
         center_phase_ff <= 16'd0;
         speed_min_ff    <= 8'd204;
         speed_max_ff    <= 8'd127;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_STEP_PERIOD:  step_period_ff  <= csr_wdata[STEP_W-1:0];
            REG_ROT_TIME_MIN: rot_min_ff      <= csr_wdata;
            REG_ROT_TIME_MAX: rot_max_ff      <= csr_wdata;
            REG_CENTER_PHASE: center_phase_ff <= csr_wdata;
            REG_SPEED_MIN:    speed_min_ff    <= csr_wdata[LEVEL_W-1:0];
            REG_SPEED_MAX:    speed_max_ff    <= csr_wdata[LEVEL_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule
